@@ design/dus_pkg.sv @@
package dus_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int ID_WIDTH_DEF    = 64;
   localparam int TAG_WIDTH_DEF   = 16;
   localparam int CNT_WIDTH       = 32;
   localparam logic [5:0] MAX_BUFFERED_RESET = 6'd32;

   typedef enum logic [2:0] {
      OP_DEPTH      = 3'd0,
      OP_SNAPSHOT   = 3'd1,
      OP_CONNECT    = 3'd2,
      OP_DISCONNECT = 3'd3,
      OP_REQUEST    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_APPLIED  = 3'd0,
      ST_BUFFERED = 3'd1,
      ST_STALE    = 3'd2,
      ST_GAP      = 3'd3,
      ST_NEED     = 3'd4,
      ST_INVALID  = 3'd5,
      ST_IGNORED  = 3'd6,
      ST_DONE     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      MD_DISCONNECTED = 3'd0,
      MD_BUFFERING    = 3'd1,
      MD_PENDING      = 3'd2,
      MD_SYNCING      = 3'd3,
      MD_LIVE         = 3'd4,
      MD_GAP          = 3'd5,
      MD_INVALID      = 3'd6,
      MD_RESYNCING    = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EVAL,
      FSM_SNAP_READ,
      FSM_SNAP_EVAL,
      FSM_OUT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic latch_in;    // capture request fields
      logic do_item;     // evaluate a non-snapshot item
      logic snap_start;  // set up snapshot state
      logic head_read;   // register queue head entry
      logic snap_step;   // evaluate registered head entry
      logic snap_close;  // build summary result
   } dus_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_snap;     // latched op is an active snapshot
      logic snap_done;   // a snapshot step hit a gap or the snapshot closed; result is final
      logic queue_empty;
      logic res_fwd;     // this snapshot step forwards an event
   } dus_sts_type;

endpackage

@@ design/depth_update_sequence_sync.sv @@
// Order book sequence sync: lines up depth deltas with a snapshot. The operation
// code travels on req_tuser; status and the forward flag travel on rsp_tuser. One
// request is taken at a time. A depth event, connect, disconnect, snapshot request
// or ignored code gives one result: the request is registered, evaluated into the
// result registers, and the result is offered; the next request is taken after that
// result transfers, so a new request is not taken before the last is through. A snapshot
// walks the event queue through a single registered read port: each queued entry is read
// and then evaluated, each forwarded result is offered in turn, then a closing result with
// rsp_tlast high. The queue holds up to QUEUE_DEPTH events.
module depth_update_sequence_sync
   import dus_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_data,     // max_buffered in [5:0]
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [2:0] req_tuser,    // operation
   // first_id, final_id, previous_final_id, snapshot_id, payload_tag
   input  logic [((4*ID_WIDTH+TAG_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [3:0] rsp_tuser,    // status, forward
   // forward_tag, forward_final_id, sync_state, gap_total, stale_total, applied_total
   output logic [((TAG_WIDTH+ID_WIDTH+3+3*CNT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);

   localparam int RSW = ((TAG_WIDTH+ID_WIDTH+3+3*CNT_WIDTH+7)/8)*8;

   dus_cmd_type cmd;
   dus_sts_type sts;
   logic [2:0]           o_status, o_mode;
   logic                 o_forward;
   logic [TAG_WIDTH-1:0] o_tag;
   logic [ID_WIDTH-1:0]  o_final;
   logic [CNT_WIDTH-1:0] o_gap, o_stale, o_applied;

   assign csr_ready = 1'b1;

   dus_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tready, .rsp_tvalid, .sts, .cmd
   );

   dus_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH), .TAG_WIDTH(TAG_WIDTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts,
      .csr_valid (csr_valid),
      .csr_data  (csr_data[5:0]),
      .in_op     (req_tuser),
      .in_first  (req_tdata[0 +: ID_WIDTH]),
      .in_final  (req_tdata[ID_WIDTH +: ID_WIDTH]),
      .in_prev   (req_tdata[2*ID_WIDTH +: ID_WIDTH]),
      .in_snap   (req_tdata[3*ID_WIDTH +: ID_WIDTH]),
      .in_tag    (req_tdata[4*ID_WIDTH +: TAG_WIDTH]),
      .o_status, .o_forward, .o_tag, .o_final, .o_mode,
      .o_gap, .o_stale, .o_applied,
      .o_last    (rsp_tlast)
   );

   assign rsp_tuser = {o_forward, o_status};
   assign rsp_tdata = RSW'({o_applied, o_stale, o_gap, o_mode, o_final, o_tag});

endmodule

@@ design/dus_ctrl.sv @@
module dus_ctrl
   import dus_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   input  dus_sts_type sts,
   output dus_cmd_type cmd
);

   fsm_type state_ff, state_in;
   logic    resume_ff, resume_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         resume_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
      end
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      unique case (state_ff)
         FSM_IDLE:
            if (req_tvalid) state_in = FSM_EVAL;
         FSM_EVAL:
            if (sts.is_snap) state_in = FSM_SNAP_READ;
            else begin
               state_in  = FSM_OUT;
               resume_in = 1'b0;
            end
         FSM_SNAP_READ: begin
            if (sts.queue_empty) begin
               state_in  = FSM_OUT;
               resume_in = 1'b0;
            end else begin
               state_in = FSM_SNAP_EVAL;
            end
         end
         FSM_SNAP_EVAL: begin
            if (sts.snap_done) begin
               state_in  = FSM_OUT;
               resume_in = 1'b0;
            end else if (sts.res_fwd) begin
               state_in  = FSM_OUT;
               resume_in = 1'b1;
            end else begin
               state_in = FSM_SNAP_READ;
            end
         end
         FSM_OUT:
            if (rsp_tready) begin
               if (resume_ff) state_in = FSM_SNAP_READ;
               else state_in = FSM_IDLE;
            end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_tready   = 1'b1;
            cmd.latch_in = req_tvalid;
         end
         FSM_EVAL: begin
            if (sts.is_snap) cmd.snap_start = 1'b1;
            else cmd.do_item = 1'b1;
         end
         FSM_SNAP_READ: begin
            if (sts.queue_empty) cmd.snap_close = 1'b1;
            else cmd.head_read = 1'b1;
         end
         FSM_SNAP_EVAL: cmd.snap_step = 1'b1;
         FSM_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

@@ design/dus_datapath.sv @@
module dus_datapath
   import dus_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF,
   parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dus_cmd_type          cmd,
   output dus_sts_type          sts,
   input  logic                 csr_valid,
   input  logic [5:0]           csr_data,
   input  logic [2:0]           in_op,
   input  logic [ID_WIDTH-1:0]  in_first,
   input  logic [ID_WIDTH-1:0]  in_final,
   input  logic [ID_WIDTH-1:0]  in_prev,
   input  logic [ID_WIDTH-1:0]  in_snap,
   input  logic [TAG_WIDTH-1:0] in_tag,
   output logic [2:0]           o_status,
   output logic                 o_forward,
   output logic [TAG_WIDTH-1:0] o_tag,
   output logic [ID_WIDTH-1:0]  o_final,
   output logic [2:0]           o_mode,
   output logic [CNT_WIDTH-1:0] o_gap,
   output logic [CNT_WIDTH-1:0] o_stale,
   output logic [CNT_WIDTH-1:0] o_applied,
   output logic                 o_last
);

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 3 * ID_WIDTH + TAG_WIDTH;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   logic [EW-1:0] mem [QUEUE_DEPTH];

   logic [5:0]           maxbuf_ff;
   mode_type             mode_ff, mode_in;
   logic                 first_ff, first_in;
   logic [ID_WIDTH-1:0]  held_ff, held_in, book_ff, book_in;
   logic [QW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CNT_WIDTH-1:0] gap_ff, gap_in, stale_ff, stale_in, appl_ff, appl_in;
   logic [2:0]           op_ff;
   logic [ID_WIDTH-1:0]  first_idr_ff, final_idr_ff, prev_idr_ff, snap_idr_ff;
   logic [TAG_WIDTH-1:0] tag_r_ff;
   logic [EW-1:0]        head_ent_ff;
   logic [2:0]           st_ff, st_in;
   logic                 fwd_ff, fwd_in, last_ff, last_in;
   logic [TAG_WIDTH-1:0] otag_ff, otag_in;
   logic [ID_WIDTH-1:0]  ofin_ff, ofin_in;
   logic                 done_in;

   logic                 push_en;
   logic [QW-1:0]        push_slot;
   logic [EW-1:0]        push_data;

   logic [ID_WIDTH-1:0]  e_first, e_fin, e_prev;
   logic [TAG_WIDTH-1:0] e_tag;
   logic [CW-1:0]        lim;

   function automatic logic [CNT_WIDTH-1:0] sat(input logic [CNT_WIDTH-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic logic [QW-1:0] wrap(input logic [CW:0] v);
      logic [CW:0] r;
      r = (v >= (CW+1)'(QUEUE_DEPTH)) ? v - (CW+1)'(QUEUE_DEPTH) : v;
      return r[QW-1:0];
   endfunction

   assign lim = (maxbuf_ff > 6'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(maxbuf_ff);
   assign {e_first, e_fin, e_prev, e_tag} = head_ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxbuf_ff <= MAX_BUFFERED_RESET;
         mode_ff   <= MD_DISCONNECTED;
         first_ff  <= 1'b0;
         held_ff   <= '0;
         book_ff   <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
         gap_ff    <= '0;
         stale_ff  <= '0;
         appl_ff   <= '0;
      end else begin
         if (csr_valid) maxbuf_ff <= csr_data;
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         held_ff   <= held_in;
         book_ff   <= book_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         gap_ff    <= gap_in;
         stale_ff  <= stale_in;
         appl_ff   <= appl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         op_ff        <= in_op;
         first_idr_ff <= in_first;
         final_idr_ff <= in_final;
         prev_idr_ff  <= in_prev;
         snap_idr_ff  <= in_snap;
         tag_r_ff     <= in_tag;
      end
      if (cmd.head_read) head_ent_ff <= mem[head_ff];
      if (push_en) mem[push_slot] <= push_data;
      st_ff   <= st_in;
      fwd_ff  <= fwd_in;
      last_ff <= last_in;
      otag_ff <= otag_in;
      ofin_ff <= ofin_in;
   end

   always_comb begin
      mode_in  = mode_ff;
      first_in = first_ff;
      held_in  = held_ff;
      book_in  = book_ff;
      head_in  = head_ff;
      count_in = count_ff;
      gap_in   = gap_ff;
      stale_in = stale_ff;
      appl_in  = appl_ff;
      st_in    = st_ff;
      fwd_in   = fwd_ff;
      last_in  = last_ff;
      otag_in  = otag_ff;
      ofin_in  = ofin_ff;
      done_in  = 1'b0;
      push_en  = 1'b0;
      push_slot = wrap({1'b0, CW'(head_ff)} + {1'b0, count_ff});
      push_data = {first_idr_ff, final_idr_ff, prev_idr_ff, tag_r_ff};

      if (cmd.do_item) begin
         fwd_in  = 1'b0;
         last_in = 1'b1;
         otag_in = '0;
         ofin_in = '0;
         st_in   = ST_IGNORED;
         case (op_ff)
            OP_DEPTH: begin
               case (mode_ff)
                  MD_DISCONNECTED: st_in = ST_IGNORED;
                  MD_INVALID: st_in = ST_INVALID;
                  MD_BUFFERING, MD_PENDING, MD_GAP, MD_RESYNCING: begin
                     if (count_ff >= lim) begin
                        head_in  = '0;
                        count_in = '0;
                        gap_in   = sat(gap_ff);
                        mode_in  = MD_INVALID;
                        st_in    = ST_INVALID;
                     end else begin
                        push_en  = (count_ff < CW'(QUEUE_DEPTH));
                        count_in = push_en ? count_ff + 1'b1 : count_ff;
                        st_in    = ST_BUFFERED;
                     end
                  end
                  default: begin
                     // syncing or live
                     if ((mode_ff == MD_SYNCING) && !first_ff) begin
                        if (final_idr_ff < held_ff) begin
                           stale_in = sat(stale_ff);
                           st_in = ST_STALE;
                        end else if (first_idr_ff > held_ff) begin
                           st_in = ST_GAP;
                        end else begin
                           first_in = 1'b1;
                           st_in = ST_APPLIED;
                        end
                     end else begin
                        if (final_idr_ff <= book_ff) begin
                           stale_in = sat(stale_ff);
                           st_in = ST_STALE;
                        end else if (prev_idr_ff != book_ff) begin
                           st_in = ST_GAP;
                        end else begin
                           st_in = ST_APPLIED;
                        end
                     end
                     if (st_in == ST_APPLIED) begin
                        book_in = final_idr_ff;
                        appl_in = sat(appl_ff);
                        mode_in = MD_LIVE;
                        fwd_in  = 1'b1;
                        otag_in = tag_r_ff;
                        ofin_in = final_idr_ff;
                     end else if (st_in == ST_GAP) begin
                        head_in   = '0;
                        count_in  = CW'(1);
                        push_en   = 1'b1;
                        push_slot = '0;
                        gap_in    = sat(gap_ff);
                        first_in  = 1'b0;
                        held_in   = '0;
                        if (mode_ff == MD_SYNCING) begin
                           mode_in = MD_RESYNCING;
                           st_in   = ST_NEED;
                        end else begin
                           mode_in = MD_GAP;
                        end
                     end
                  end
               endcase
            end
            OP_CONNECT, OP_DISCONNECT: begin
               book_in  = '0;
               head_in  = '0;
               count_in = '0;
               first_in = 1'b0;
               held_in  = '0;
               mode_in  = (op_ff == OP_CONNECT) ? MD_BUFFERING : MD_DISCONNECTED;
               st_in    = ST_DONE;
            end
            OP_REQUEST: begin
               if (mode_ff != MD_DISCONNECTED) begin
                  mode_in = MD_PENDING;
                  st_in   = ST_DONE;
               end
            end
            default: st_in = ST_IGNORED;
         endcase
      end

      if (cmd.snap_start) begin
         mode_in  = MD_SYNCING;
         first_in = 1'b0;
         held_in  = snap_idr_ff;
         book_in  = snap_idr_ff;
         fwd_in   = 1'b0;
      end

      if (cmd.snap_step) begin
         // pop head entry held in head_ent_ff
         head_in  = wrap({1'b0, CW'(head_ff)} + (CW+1)'(1));
         count_in = count_ff - 1'b1;
         fwd_in   = 1'b0;
         last_in  = 1'b1;
         otag_in  = '0;
         ofin_in  = '0;
         if (!first_ff) begin
            if (e_fin < held_ff) begin
               stale_in = sat(stale_ff);    // leading stale drop, keep going
            end else if (e_first > held_ff) begin
               done_in = 1'b1;
            end else begin
               first_in = 1'b1;
               book_in  = e_fin;
               appl_in  = sat(appl_ff);
               mode_in  = MD_LIVE;
               fwd_in   = 1'b1;
               last_in  = 1'b0;
               st_in    = ST_APPLIED;
               otag_in  = e_tag;
               ofin_in  = e_fin;
            end
         end else begin
            if (e_fin <= book_ff) begin
               stale_in = sat(stale_ff);
            end else if (e_prev != book_ff) begin
               done_in = 1'b1;
            end else begin
               book_in = e_fin;
               appl_in = sat(appl_ff);
               mode_in = MD_LIVE;
               fwd_in  = 1'b1;
               last_in = 1'b0;
               st_in   = ST_APPLIED;
               otag_in = e_tag;
               ofin_in = e_fin;
            end
         end
         if (done_in) begin
            // gap: queue holds just this event, then resync
            head_in   = '0;
            count_in  = CW'(1);
            push_en   = 1'b1;
            push_slot = '0;
            push_data = head_ent_ff;
            gap_in    = sat(gap_ff);
            first_in  = 1'b0;
            held_in   = '0;
            mode_in   = MD_RESYNCING;
            st_in     = ST_NEED;
         end
      end

      if (cmd.snap_close) begin
         done_in = 1'b1;
         fwd_in  = 1'b0;
         last_in = 1'b1;
         otag_in = '0;
         ofin_in = '0;
         st_in   = first_ff ? ST_APPLIED : ST_BUFFERED;
      end
   end

   always_comb begin
      sts.is_snap     = (op_ff == OP_SNAPSHOT) && (mode_ff != MD_DISCONNECTED);
      sts.queue_empty = (count_ff == '0);
      sts.snap_done   = done_in;
      sts.res_fwd     = fwd_in;
   end

   assign o_status  = st_ff;
   assign o_forward = fwd_ff;
   assign o_tag     = otag_ff;
   assign o_final   = ofin_ff;
   assign o_mode    = mode_ff;
   assign o_gap     = gap_ff;
   assign o_stale   = stale_ff;
   assign o_applied = appl_ff;
   assign o_last    = last_ff;

endmodule
